### sv/ipm_pkg.sv
// ----------------------------------------------------------------------------
// Injector pulse monitor package
// Shared sizes, thresholds, register indexes and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ipm_pkg;

  // Channel layout: injectors first, then the ignition coil.
  localparam int NUM_INJECTORS = 4;
  localparam int TIME_BITS     = 48;
  localparam int NUM_CH        = NUM_INJECTORS + 1;
  localparam int COIL_CH       = NUM_INJECTORS;
  localparam int CH_W          = 3;
  localparam int IDX_W         = $clog2(NUM_CH);
  localparam bit HAS_PAIR      = (NUM_INJECTORS >= 2);

  localparam int WIDTH_W = 32;
  localparam int PROD_W  = WIDTH_W + 7;

  // Stream word layouts.
  localparam int IN_DATA_W    = ((TIME_BITS + 7) / 8) * 8;
  localparam int IN_USER_W    = CH_W + 1;
  localparam int OUT_FIELDS_W = NUM_CH + WIDTH_W + NUM_INJECTORS + 3;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_RUNNING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_RPM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_PCT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_US   = 2'd3;

  localparam logic        RESET_RUNNING   = 1'b1;
  localparam logic [12:0] RESET_RPM       = 13'd1000;
  localparam logic [6:0]  RESET_THROTTLE  = 7'd15;
  localparam logic [15:0] RESET_MIN_PULSE = 16'd50;

  // Thresholds.
  localparam logic [31:0] WIDTH_MAX         = 32'hFFFF_FFFF;
  localparam logic [31:0] CHECK_INTERVAL_US = 32'd1_000_000;
  localparam logic [31:0] MISSING_AFTER_US  = 32'd2_000_000;
  localparam logic [6:0]  LOW_INJ_THROTTLE  = 7'd50;
  localparam logic [31:0] LOW_INJ_WIDTH     = 32'd3000;
  localparam logic [12:0] DWELL_RPM         = 13'd3000;
  localparam logic [31:0] DWELL_LIMIT       = 32'd4000;
  localparam logic [6:0]  IMB_SCALE         = 7'd100;
  localparam logic [6:0]  IMB_LOW           = 7'd85;
  localparam logic [6:0]  IMB_HIGH          = 7'd115;

  typedef struct packed {
    logic        running;
    logic [12:0] rpm;
    logic [6:0]  throttle;
    logic [15:0] min_pulse;
  } cfg_t;

  // Channel state results after the current edge has been applied.
  typedef struct packed {
    logic [NUM_CH-1:0]        active_mask;
    logic [WIDTH_W-1:0]       width_out;
    logic                     updated;
    logic [NUM_INJECTORS-1:0] width_zero;
    logic [WIDTH_W-1:0]       inj1_w;
    logic [WIDTH_W-1:0]       inj2_w;
    logic [WIDTH_W-1:0]       coil_w;
  } chan_res_t;

  typedef struct packed {
    logic                     checked;
    logic [NUM_INJECTORS-1:0] missing;
    logic                     imbalance;
    logic                     low_inj;
    logic                     dwell;
  } anom_res_t;

endpackage

`default_nettype wire

### sv/ipm_chan_state.sv
// ----------------------------------------------------------------------------
// Injector pulse monitor channel state
// Start times, latched widths and active flags for all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ipm_chan_state (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic [ipm_pkg::CH_W-1:0]      ch,
  input  wire logic                          rising,
  input  wire logic [ipm_pkg::TIME_BITS-1:0] t,
  input  wire logic [15:0]                   min_pulse,
  output ipm_pkg::chan_res_t                 res
);

  logic [ipm_pkg::TIME_BITS-1:0] start_r [ipm_pkg::NUM_CH];
  logic [ipm_pkg::WIDTH_W-1:0]   width_r [ipm_pkg::NUM_CH];
  logic [ipm_pkg::NUM_CH-1:0]    active_r;
  logic [ipm_pkg::NUM_CH-1:0]    active_nxt;

  logic                          ch_ok;
  logic [ipm_pkg::IDX_W-1:0]     idx;
  logic [ipm_pkg::TIME_BITS-1:0] start_sel;
  logic [ipm_pkg::TIME_BITS-1:0] diff;
  logic                          w_ok;
  logic [ipm_pkg::WIDTH_W-1:0]   new_w;
  logic [ipm_pkg::WIDTH_W-1:0]   after [ipm_pkg::NUM_CH];

  assign ch_ok     = (ch < ipm_pkg::CH_W'(ipm_pkg::NUM_CH));
  assign idx       = ipm_pkg::IDX_W'(ch);
  assign start_sel = start_r[idx];
  assign diff      = t - start_sel;

  // A width is only taken when the channel was ever started and it beats the minimum.
  assign w_ok  = ch_ok && !rising && (start_sel != '0)
                 && (diff > ipm_pkg::TIME_BITS'(min_pulse));
  assign new_w = (diff > ipm_pkg::TIME_BITS'(ipm_pkg::WIDTH_MAX)) ?
                 ipm_pkg::WIDTH_MAX : diff[ipm_pkg::WIDTH_W-1:0];

  always_comb begin
    active_nxt = active_r;
    for (int c = 0; c < ipm_pkg::NUM_CH; c++) begin
      after[c] = (w_ok && (idx == ipm_pkg::IDX_W'(c))) ? new_w : width_r[c];
      if (ch_ok && (idx == ipm_pkg::IDX_W'(c))) begin
        active_nxt[c] = rising;
      end
    end
  end

  always_comb begin
    res.active_mask = active_nxt;
    res.width_out   = ch_ok ? after[idx] : '0;
    res.updated     = w_ok;
    for (int i = 0; i < ipm_pkg::NUM_INJECTORS; i++) begin
      res.width_zero[i] = (after[i] == '0);
    end
    res.inj1_w = after[0];
    res.inj2_w = ipm_pkg::HAS_PAIR ? after[1] : '0;
    res.coil_w = after[ipm_pkg::COIL_CH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int c = 0; c < ipm_pkg::NUM_CH; c++) begin
        start_r[c] <= '0;
        width_r[c] <= '0;
      end
    end else if (fire) begin
      active_r <= active_nxt;
      for (int c = 0; c < ipm_pkg::NUM_CH; c++) begin
        if (ch_ok && rising && (idx == ipm_pkg::IDX_W'(c))) begin
          start_r[c] <= t;
        end
        width_r[c] <= after[c];
      end
    end
  end

`ifndef SYNTHESIS
  a_rise_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch_ok && rising |=> active_r[$past(idx)])
    else $error("rising edge did not set the active flag");
`endif

endmodule

`default_nettype wire

### sv/ipm_anomaly.sv
// ----------------------------------------------------------------------------
// Injector pulse monitor anomaly checks
// Once-per-second gate on event time and the four anomaly flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ipm_anomaly (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic [ipm_pkg::TIME_BITS-1:0] t,
  input  ipm_pkg::cfg_t                      cfg,
  input  ipm_pkg::chan_res_t                 chan,
  output ipm_pkg::anom_res_t                 res
);

  logic [ipm_pkg::TIME_BITS-1:0] last_r;
  logic [ipm_pkg::TIME_BITS-1:0] elapsed;
  logic                          due;
  logic [ipm_pkg::PROD_W-1:0]    p1;
  logic [ipm_pkg::PROD_W-1:0]    p2_low;
  logic [ipm_pkg::PROD_W-1:0]    p2_high;

  // Elapsed time wraps, so a backward step looks like a long gap.
  assign elapsed = t - last_r;
  assign due     = (elapsed >= ipm_pkg::TIME_BITS'(ipm_pkg::CHECK_INTERVAL_US));

  assign p1      = ipm_pkg::PROD_W'(chan.inj1_w) * ipm_pkg::PROD_W'(ipm_pkg::IMB_SCALE);
  assign p2_low  = ipm_pkg::PROD_W'(chan.inj2_w) * ipm_pkg::PROD_W'(ipm_pkg::IMB_LOW);
  assign p2_high = ipm_pkg::PROD_W'(chan.inj2_w) * ipm_pkg::PROD_W'(ipm_pkg::IMB_HIGH);

  always_comb begin
    res.checked   = due;
    res.missing   = '0;
    res.imbalance = 1'b0;
    res.low_inj   = 1'b0;
    res.dwell     = 1'b0;
    if (due) begin
      if (cfg.running && (cfg.rpm != '0)
          && (t > ipm_pkg::TIME_BITS'(ipm_pkg::MISSING_AFTER_US))) begin
        res.missing = chan.width_zero;
      end
      res.imbalance = (chan.inj1_w != '0) && (chan.inj2_w != '0)
                      && ((p1 < p2_low) || (p1 > p2_high));
      res.low_inj   = (cfg.throttle > ipm_pkg::LOW_INJ_THROTTLE)
                      && (chan.inj1_w < ipm_pkg::LOW_INJ_WIDTH);
      res.dwell     = (cfg.rpm > ipm_pkg::DWELL_RPM)
                      && (chan.coil_w > ipm_pkg::DWELL_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (fire && due) begin
      last_r <= t;
    end
  end

`ifndef SYNTHESIS
  a_check_moves_mark: assert property (@(posedge clk) disable iff (!rst_n)
    fire && due |=> (last_r == $past(t)))
    else $error("anomaly check did not record its time");
`endif

endmodule

`default_nettype wire

### sv/injector_pulse_monitor_core.sv
// ----------------------------------------------------------------------------
// Injector pulse monitor core
// Pulse width capture on four injector lines and one coil line, with flags.
// ----------------------------------------------------------------------------
// Each input word is one timestamped edge. The block takes one word per clock
// while the output is not stalled and returns exactly one result word for it.
// The word lands in an input register, the channel state and the anomaly
// checks are evaluated in a single combinational pass from there, and the
// result is held in an output register. The state that the next word depends
// on (start times, latched widths, active flags and the time of the last
// check) is updated at the same edge that loads the result, so back-to-back
// words always see the effect of the word before them. The input register
// and the output register together act as a skid, so a new word is accepted
// while a finished result still waits to be taken. The configuration port is
// always ready and should only be written while the block holds no word in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module injector_pulse_monitor_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Edge events.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tdata: [47:0] event_time_us.
  input  wire logic [ipm_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: [2:0] channel, [3] is_rising.
  input  wire logic [ipm_pkg::IN_USER_W-1:0]   in_tuser,
  // Results.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata: [4:0] active_mask, [36:5] pulse_width_us, [40:37] missing_mask,
  // [41] injector_imbalance, [42] low_injection, [43] long_dwell, rest zero.
  output logic [ipm_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser: [0] width_updated, [1] anomaly_checked.
  output logic [ipm_pkg::OUT_USER_W-1:0]       out_tuser,
  // Register writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ipm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ipm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ipm_pkg::cfg_t cfg_r;

  logic                          in_valid_r;
  logic [ipm_pkg::CH_W-1:0]      in_ch_r;
  logic                          in_rise_r;
  logic [ipm_pkg::TIME_BITS-1:0] in_time_r;

  logic                            out_valid_r;
  logic [ipm_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [ipm_pkg::OUT_USER_W-1:0]  out_user_r;
  logic [ipm_pkg::OUT_DATA_W-1:0]  out_data_nxt;
  logic [ipm_pkg::OUT_USER_W-1:0]  out_user_nxt;

  logic               advance;
  logic               fire;
  logic               in_take;
  ipm_pkg::chan_res_t chan_res;
  ipm_pkg::anom_res_t anom_res;

  // The held word moves on whenever the output register is free or emptying.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.running   <= ipm_pkg::RESET_RUNNING;
      cfg_r.rpm       <= ipm_pkg::RESET_RPM;
      cfg_r.throttle  <= ipm_pkg::RESET_THROTTLE;
      cfg_r.min_pulse <= ipm_pkg::RESET_MIN_PULSE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipm_pkg::REG_ENGINE_RUNNING: begin
          cfg_r.running <= cfg_data[0];
        end
        ipm_pkg::REG_ENGINE_RPM: begin
          cfg_r.rpm <= cfg_data[12:0];
        end
        ipm_pkg::REG_THROTTLE_PCT: begin
          cfg_r.throttle <= cfg_data[6:0];
        end
        ipm_pkg::REG_MIN_PULSE_US: begin
          cfg_r.min_pulse <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch_r   <= in_tuser[ipm_pkg::CH_W-1:0];
      in_rise_r <= in_tuser[ipm_pkg::CH_W];
      in_time_r <= in_tdata[ipm_pkg::TIME_BITS-1:0];
    end
  end

  ipm_chan_state u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .ch        (in_ch_r),
    .rising    (in_rise_r),
    .t         (in_time_r),
    .min_pulse (cfg_r.min_pulse),
    .res       (chan_res)
  );

  ipm_anomaly u_anom (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .t     (in_time_r),
    .cfg   (cfg_r),
    .chan  (chan_res),
    .res   (anom_res)
  );

  always_comb begin
    out_data_nxt = ipm_pkg::OUT_DATA_W'({anom_res.dwell, anom_res.low_inj, anom_res.imbalance,
                                         anom_res.missing, chan_res.width_out,
                                         chan_res.active_mask});
    out_user_nxt = {anom_res.checked, chan_res.updated};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

`ifndef SYNTHESIS
  a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[0]
    |-> (out_data_r[ipm_pkg::NUM_CH +: ipm_pkg::WIDTH_W] != '0))
    else $error("latched width of zero reported as an update");

  a_flags_need_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r[1]
    |-> (out_data_r[ipm_pkg::OUT_FIELDS_W-1:ipm_pkg::NUM_CH + ipm_pkg::WIDTH_W] == '0))
    else $error("anomaly flags set without a check");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && !in_valid_r || $past(in_take))
    else $error("processed word did not reach the result register");
`endif

endmodule

`default_nettype wire
